[rtl/md5_block_compression_assert.svh]
// ----------------------------------------------------------------------------
// md5 block compression assertion macros
// concurrent assertion helpers used by md5_ctrl, compiled out when
// NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef MD5_BLOCK_COMPRESSION_ASSERT_SVH
`define MD5_BLOCK_COMPRESSION_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MD5_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("md5 assertion failed");

// next-cycle implication
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("md5 assertion failed");

`else

`define MD5_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/md5_pkg.sv]
// ----------------------------------------------------------------------------
// md5 package
// shared constants, command struct and round helper functions
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam int WORD_W   = 32;
  localparam int BUF_AW   = 4;
  localparam int ROUND_W  = 6;
  localparam int DIGEST_W = 4 * WORD_W;

  localparam logic [BUF_AW-1:0]  LAST_WORD  = 4'd15;
  localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;

  localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
  localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
  localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
  localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

  localparam logic [1:0] STAGE_F = 2'd0;
  localparam logic [1:0] STAGE_G = 2'd1;
  localparam logic [1:0] STAGE_H = 2'd2;
  localparam logic [1:0] STAGE_I = 2'd3;

  localparam logic [WORD_W-1:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TABLE [4][4] = '{
    '{5'd7, 5'd12, 5'd17, 5'd22},
    '{5'd5, 5'd9,  5'd14, 5'd20},
    '{5'd4, 5'd11, 5'd16, 5'd23},
    '{5'd6, 5'd10, 5'd15, 5'd21}
  };

  typedef struct packed {
    logic                 wr_en;
    logic [BUF_AW-1:0]    wr_idx;
    logic                 load_iv;
    logic                 load_work;
    logic                 round_en;
    logic [ROUND_W-1:0]   round_idx;
    logic                 finish;
  } md5_cmd_t;

  // message word index for a round
  function automatic logic [BUF_AW-1:0] msg_index(input logic [ROUND_W-1:0] r);
    logic [BUF_AW-1:0] rl;
    logic [BUF_AW-1:0] idx;
    rl = r[BUF_AW-1:0];
    unique case (r[5:4])
      STAGE_F: idx = rl;
      STAGE_G: idx = 4'(rl * 4'd5 + 4'd1);
      STAGE_H: idx = 4'(rl * 4'd3 + 4'd5);
      STAGE_I: idx = 4'(rl * 4'd7);
    endcase
    return idx;
  endfunction

  function automatic logic [WORD_W-1:0] round_fn(input logic [1:0] stage,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] f;
    unique case (stage)
      STAGE_F: f = (b & c) | (~b & d);
      STAGE_G: f = (b & d) | (c & ~d);
      STAGE_H: f = b ^ c ^ d;
      STAGE_I: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input logic [4:0] s);
    logic [2*WORD_W-1:0] t;
    t = {x, x} << s;
    return t[2*WORD_W-1:WORD_W];
  endfunction

endpackage

[rtl/md5_ctrl.sv]
// ----------------------------------------------------------------------------
// md5 controller
// word counting, round sequencing and result handshake
// ----------------------------------------------------------------------------
`include "md5_block_compression_assert.svh"

module md5_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tuser,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output md5_pkg::md5_cmd_t cmd
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_FINAL = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [BUF_AW-1:0]    count_r, count_nxt;
  logic [ROUND_W-1:0]   round_r, round_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BUF_AW-1:0]    count_eff;
  logic                 accept;
  logic                 closes_block;

  // a start flag restarts the block at word zero
  assign count_eff    = in_tuser ? '0 : count_r;
  // hold off the closing word while the previous digest is still waiting
  assign in_tready    = (state_r == ST_IDLE) && !(out_valid_r && (count_r == LAST_WORD));
  assign accept       = in_tvalid && in_tready;
  assign closes_block = accept && (count_eff == LAST_WORD);
  assign out_tvalid   = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    round_nxt     = round_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (closes_block) begin
          count_nxt = '0;
          round_nxt = '0;
          state_nxt = ST_ROUND;
        end else if (accept) begin
          count_nxt = count_eff + 4'd1;
        end
      end
      ST_ROUND: begin
        round_nxt = round_r + 6'd1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd.wr_en     = accept;
    cmd.wr_idx    = count_eff;
    cmd.load_iv   = accept && in_tuser;
    cmd.load_work = closes_block;
    cmd.round_en  = (state_r == ST_ROUND);
    cmd.round_idx = round_r;
    cmd.finish    = (state_r == ST_FINAL);
  end

  `MD5_ASSERT_NEXT(a_close_starts_rounds, clk, rst_n, closes_block, (state_r == ST_ROUND) && (round_r == '0))
  `MD5_ASSERT_NEXT(a_last_round_to_final, clk, rst_n, (state_r == ST_ROUND) && (round_r == LAST_ROUND), state_r == ST_FINAL)
  `MD5_ASSERT_IMPLY(a_final_out_free, clk, rst_n, state_r == ST_FINAL, !out_valid_r)
  `MD5_ASSERT_NEXT(a_final_sets_valid, clk, rst_n, state_r == ST_FINAL, out_valid_r && (state_r == ST_IDLE))

endmodule

[rtl/md5_dp.sv]
// ----------------------------------------------------------------------------
// md5 datapath
// block buffer, chaining words, working words and the shared round unit
// ----------------------------------------------------------------------------
module md5_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  md5_pkg::md5_cmd_t             cmd,
  input  logic [md5_pkg::WORD_W-1:0]    in_word,
  output logic [md5_pkg::DIGEST_W-1:0]  digest
);
  import md5_pkg::*;

  logic [WORD_W-1:0]   buf_r [16];
  logic [WORD_W-1:0]   ch_a_r, ch_b_r, ch_c_r, ch_d_r;
  logic [WORD_W-1:0]   wa_r, wb_r, wc_r, wd_r;
  logic [DIGEST_W-1:0] digest_r;

  logic [1:0]          stage;
  logic [WORD_W-1:0]   fv;
  logic [WORD_W-1:0]   sum;
  logic [WORD_W-1:0]   nb;
  logic [WORD_W-1:0]   sum_a, sum_b, sum_c, sum_d;

  assign stage = cmd.round_idx[5:4];
  assign fv    = round_fn(stage, wb_r, wc_r, wd_r);
  assign sum   = wa_r + fv + buf_r[msg_index(cmd.round_idx)] + K_TABLE[cmd.round_idx];
  assign nb    = wb_r + rotl(sum, ROT_TABLE[stage][cmd.round_idx[1:0]]);

  assign sum_a = ch_a_r + wa_r;
  assign sum_b = ch_b_r + wb_r;
  assign sum_c = ch_c_r + wc_r;
  assign sum_d = ch_d_r + wd_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      buf_r[cmd.wr_idx] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_a_r <= IV_A;
      ch_b_r <= IV_B;
      ch_c_r <= IV_C;
      ch_d_r <= IV_D;
    end else if (cmd.load_iv) begin
      ch_a_r <= IV_A;
      ch_b_r <= IV_B;
      ch_c_r <= IV_C;
      ch_d_r <= IV_D;
    end else if (cmd.finish) begin
      ch_a_r <= sum_a;
      ch_b_r <= sum_b;
      ch_c_r <= sum_c;
      ch_d_r <= sum_d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      wa_r <= ch_a_r;
      wb_r <= ch_b_r;
      wc_r <= ch_c_r;
      wd_r <= ch_d_r;
    end else if (cmd.round_en) begin
      wa_r <= wd_r;
      wb_r <= nb;
      wc_r <= wb_r;
      wd_r <= wc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      digest_r <= {sum_d, sum_c, sum_b, sum_a};
    end
  end

  assign digest = digest_r;

endmodule

[rtl/md5_block_compression.sv]
// ----------------------------------------------------------------------------
// md5 block compression
// top level: md5 compression function over pre-padded 32-bit message words
// ----------------------------------------------------------------------------
// Message words are taken one per cycle while the block is idle. The
// sixteenth word of a block starts the compression: one round per cycle
// through a single shared round unit for all 64 rounds, then a final step
// to add the working words into the chaining words and load the output
// register. Input is held off through the rounds and that final step, so
// no word of the next block is taken while one is being compressed. The
// closing word of the next block is also held off while the previous
// digest has not been taken. A set start flag reloads the initial chaining
// words and makes its word the first word of a new block.
module md5_block_compression (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [md5_pkg::WORD_W-1:0]    in_tdata,   // message_word
  input  logic                          in_tuser,   // starts_message
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [md5_pkg::DIGEST_W-1:0]  out_tdata   // digest_a, digest_b, digest_c, digest_d
);
  import md5_pkg::*;

  md5_cmd_t cmd;

  md5_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  md5_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_word (in_tdata),
    .digest  (out_tdata)
  );

endmodule

[test/md5_digest_checker.sv]
// ----------------------------------------------------------------------------
// md5 digest checker
// watches both streams of md5_block_compression, keeps its own copy of the
// chaining words and block buffer, predicts each digest and compares it
// field by field with what the block hands out
// ----------------------------------------------------------------------------
module md5_digest_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [md5_pkg::WORD_W-1:0]    in_tdata,   // message_word
  input  logic                          in_tuser,   // starts_message
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [md5_pkg::DIGEST_W-1:0]  out_tdata,  // digest_a, digest_b, digest_c, digest_d
  output int                            pending_digests,
  output int                            mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import md5_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } digest_t;

  logic [WORD_W-1:0] chain_words [4];
  logic [WORD_W-1:0] block_words [16];
  logic [BUF_AW-1:0] word_pos;
  digest_t           expected_digests [$];
  int                fails;

  function automatic logic [WORD_W-1:0] rotate_left(input logic [WORD_W-1:0] x, input int n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic void reload_chain();
    chain_words[0] = IV_A;
    chain_words[1] = IV_B;
    chain_words[2] = IV_C;
    chain_words[3] = IV_D;
  endfunction

  // 64 rounds over the buffered block, then the chaining add
  function automatic digest_t mix_block();
    logic [WORD_W-1:0] a, b, c, d, f, sum, nb;
    logic [1:0]        stage;
    int                g;
    digest_t           res;
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    for (int r = 0; r < 64; r++) begin
      stage = 2'(r / 16);
      case (stage)
        STAGE_F: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        STAGE_G: begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) % 16;
        end
        STAGE_H: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      sum = a + f + block_words[g] + K_TABLE[r];
      nb = b + rotate_left(sum, int'(ROT_TABLE[stage][r % 4]));
      a = d;
      d = c;
      c = b;
      b = nb;
    end
    res.a = chain_words[0] + a;
    res.b = chain_words[1] + b;
    res.c = chain_words[2] + c;
    res.d = chain_words[3] + d;
    return res;
  endfunction

  always @(posedge clk) begin
    digest_t got, want;
    if (!rst_n) begin
      reload_chain();
      word_pos = '0;
      expected_digests.delete();
      fails = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        // start flag drops any partial block and restarts the chain
        if (in_tuser) begin
          reload_chain();
          word_pos = '0;
        end
        block_words[word_pos] = in_tdata;
        if (word_pos == LAST_WORD) begin
          want = mix_block();
          chain_words[0] = want.a;
          chain_words[1] = want.b;
          chain_words[2] = want.c;
          chain_words[3] = want.d;
          expected_digests.push_back(want);
          word_pos = '0;
        end else begin
          word_pos = word_pos + 1'b1;
        end
      end
      if (out_tvalid && out_tready) begin
        got.a = out_tdata[WORD_W-1:0];
        got.b = out_tdata[2*WORD_W-1:WORD_W];
        got.c = out_tdata[3*WORD_W-1:2*WORD_W];
        got.d = out_tdata[4*WORD_W-1:3*WORD_W];
        if (expected_digests.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: digest transfer with none expected: %h %h %h %h",
                     $realtime, got.a, got.b, got.c, got.d);
        end else begin
          want = expected_digests.pop_front();
          if (got.a !== want.a || got.b !== want.b || got.c !== want.c || got.d !== want.d) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: digest mismatch", $realtime);
              $display("  expected a=%h b=%h c=%h d=%h", want.a, want.b, want.c, want.d);
              $display("  actual   a=%h b=%h c=%h d=%h", got.a, got.b, got.c, got.d);
            end
          end
        end
      end
    end
    pending_digests <= expected_digests.size();
    mismatch_count  <= fails;
  end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// md5 block compression testbench
// drives random message words in random bursts, stalls the digest stream on
// a changing pattern and lets the checker predict and compare every digest
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import md5_pkg::*;

  localparam int TOTAL_WORDS = 1650;
  localparam int DRAIN_AT    = 900;
  localparam int HOLD_START  = 2500;
  localparam int HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT = 800000;

  typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MASK} ready_mode_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [WORD_W-1:0]    in_tdata  = '0;   // message_word
  logic                 in_tuser  = 1'b0; // starts_message
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DIGEST_W-1:0]  out_tdata;        // digest_a, digest_b, digest_c, digest_d
  int                   pending_digests;
  int                   mismatch_count;
  int                   words_sent;
  int                   burst_left;

  md5_block_compression dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  md5_digest_checker digest_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .pending_digests (pending_digests),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // one word transfer, with a random gap whenever a burst runs out
  task automatic send_word(input logic [WORD_W-1:0] word, input logic first);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(60, 90);
        default: gap = $urandom_range(1, 6);
      endcase
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // digest receiver: random patterns plus one long hold-off
  initial begin
    ready_mode_t mode;
    int          span;
    int          age;
    logic [7:0]  mask;
    span = 0;
    age  = 0;
    mode = READY_ALWAYS;
    mask = '1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      age++;
      if (age == HOLD_START) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = ready_mode_t'($urandom_range(0, 3));
          span = $urandom_range(8, 120);
          mask = 8'($urandom);
        end
        span--;
        case (mode)
          READY_ALWAYS: out_tready <= 1'b1;
          READY_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
          READY_SPARSE: out_tready <= ($urandom_range(0, 9) == 0);
          default:      out_tready <= mask[age % 8];
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int kind;
    int count;
    bit drained;
    words_sent = 0;
    burst_left = 0;
    drained    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first block with no start flag: chains from the reset values
    for (int i = 0; i < 16; i++)
      send_word((i == 6) ? 32'h8000_0001 : ((i % 2) ? 32'hffff_ffff : 32'h0), 1'b0);
    // start on a block boundary, then a restart in the middle of a block
    send_word(32'hffff_ffff, 1'b1);
    for (int i = 0; i < 3; i++)
      send_word(random_word(), 1'b0);
    send_word(32'h8000_0000, 1'b1);
    for (int i = 0; i < 15; i++)
      send_word(random_word(), 1'b0);

    while (words_sent < TOTAL_WORDS) begin
      if (!drained && words_sent >= DRAIN_AT) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_digests != 0);
        burst_left = 0;
        drained = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        // well-formed message of whole blocks
        count = 16 * (($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3));
        for (int j = 0; j < count; j++)
          send_word(random_word(), j == 0);
      end else if (kind == 8) begin
        // message cut short, the next start may land mid-block
        count = $urandom_range(1, 40);
        for (int j = 0; j < count; j++)
          send_word(random_word(), j == 0);
      end else begin
        count = $urandom_range(1, 20);
        for (int j = 0; j < count; j++)
          send_word(random_word(), $urandom_range(0, 3) == 0);
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_digests != 0);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_digests == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
